### design/stat_pkg.sv
// ----------------------------------------------------------------------------
// stat_pkg: shared types and codes for the sorted term accumulate table
// beat layouts, operation and status codes, and the cell command word
// ----------------------------------------------------------------------------
package stat_pkg;

  localparam int MAX_TERMS_DEF = 32;
  localparam int EXP_W         = 16;
  localparam int COEF_W        = 32;

  // operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // status codes
  localparam logic [2:0] ST_PLACED  = 3'd0;
  localparam logic [2:0] ST_MERGED  = 3'd1;
  localparam logic [2:0] ST_DROPPED = 3'd2;
  localparam logic [2:0] ST_TERM    = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;
  localparam logic [2:0] ST_CLEARED = 3'd5;

  typedef struct packed {
    logic [1:0]               operation;
    logic signed [EXP_W-1:0]  term_exponent;
    logic signed [COEF_W-1:0] term_coefficient;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]               status;
    logic signed [EXP_W-1:0]  out_exponent;
    logic signed [COEF_W-1:0] out_coefficient;
    logic                     last;
  } out_beat_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_MERGE,
    CELL_ROTATE
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t               mode;
    logic signed [EXP_W-1:0]  exponent;
    logic signed [COEF_W-1:0] coefficient;
  } cell_cmd_t;

endpackage

### design/stat_cell.sv
// ----------------------------------------------------------------------------
// stat_cell: one slot of the sorted term chain
// holds one term, compares it with the broadcast term, merges, shifts or
// rotates with its neighbors
// ----------------------------------------------------------------------------
module stat_cell (
  input  logic                              clk,
  input  stat_pkg::cell_cmd_t               cmd,
  input  logic                              valid_i,
  input  logic                              tail_i,
  input  logic                              left_gt_i,
  input  logic signed [stat_pkg::EXP_W-1:0]  left_exp_i,
  input  logic signed [stat_pkg::COEF_W-1:0] left_coef_i,
  input  logic signed [stat_pkg::EXP_W-1:0]  right_exp_i,
  input  logic signed [stat_pkg::COEF_W-1:0] right_coef_i,
  input  logic signed [stat_pkg::EXP_W-1:0]  head_exp_i,
  input  logic signed [stat_pkg::COEF_W-1:0] head_coef_i,
  output logic signed [stat_pkg::EXP_W-1:0]  exp_o,
  output logic signed [stat_pkg::COEF_W-1:0] coef_o,
  output logic                              gt_o,
  output logic                              match_o
);

  logic signed [stat_pkg::EXP_W-1:0]  exp_r, exp_nxt;
  logic signed [stat_pkg::COEF_W-1:0] coef_r, coef_nxt;
  logic [stat_pkg::COEF_W:0]          sum;
  logic signed [stat_pkg::COEF_W-1:0] sat_sum;

  assign gt_o    = valid_i && (exp_r > cmd.exponent);
  assign match_o = valid_i && (exp_r == cmd.exponent);
  assign exp_o   = exp_r;
  assign coef_o  = coef_r;

  // saturating add of the broadcast coefficient
  assign sum = {coef_r[stat_pkg::COEF_W-1], coef_r}
             + {cmd.coefficient[stat_pkg::COEF_W-1], cmd.coefficient};

  always_comb begin
    if (sum[stat_pkg::COEF_W] != sum[stat_pkg::COEF_W-1]) begin
      sat_sum = sum[stat_pkg::COEF_W] ? {1'b1, {(stat_pkg::COEF_W-1){1'b0}}}
                                      : {1'b0, {(stat_pkg::COEF_W-1){1'b1}}};
    end else begin
      sat_sum = sum[stat_pkg::COEF_W-1:0];
    end
  end

  always_comb begin
    exp_nxt  = exp_r;
    coef_nxt = coef_r;
    case (cmd.mode)
      stat_pkg::CELL_INSERT: begin
        if (!gt_o && left_gt_i) begin
          exp_nxt  = cmd.exponent;
          coef_nxt = cmd.coefficient;
        end else if (!left_gt_i) begin
          exp_nxt  = left_exp_i;
          coef_nxt = left_coef_i;
        end
      end
      stat_pkg::CELL_MERGE: begin
        if (match_o) begin
          coef_nxt = sat_sum;
        end
      end
      stat_pkg::CELL_ROTATE: begin
        if (tail_i) begin
          exp_nxt  = head_exp_i;
          coef_nxt = head_coef_i;
        end else begin
          exp_nxt  = right_exp_i;
          coef_nxt = right_coef_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    exp_r  <= exp_nxt;
    coef_r <= coef_nxt;
  end

endmodule

### design/sorted_term_accumulate_table_unit.sv
// ----------------------------------------------------------------------------
// sorted_term_accumulate_table_unit: bounded sorted table of polynomial terms
// insert merges or places a term in descending exponent order or drops it
// when full, readout streams every term, clear empties the table
// ----------------------------------------------------------------------------
//  channel | ports                          | beat
//  --------+--------------------------------+-------------------------------
//  input   | in_valid, in_stall, in_data    | operation, exponent, coefficient
//  output  | out_valid, out_stall, out_data | status, exponent, coefficient, last
//
// insert: every cell compares its term with the broadcast term at once and
// shifts, merges or takes it; clear only resets the term count.
// readout accepts the request, then the chain rotates toward cell 0 once
// per emitted term; an empty table answers with a single empty beat.
// reset clears state, count and out_valid; cell contents and out_data are
// not cleared. a stalled output register holds the chain and the input.
// ----------------------------------------------------------------------------
module sorted_term_accumulate_table_unit #(
  parameter int MAX_TERMS = stat_pkg::MAX_TERMS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  stat_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output stat_pkg::out_beat_t out_data
);

  localparam int CW = $clog2(MAX_TERMS + 1);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  stat_pkg::out_beat_t out_data_r, out_data_nxt;

  stat_pkg::cell_cmd_t cmd;

  // per-cell neighbor wiring
  logic signed [stat_pkg::EXP_W-1:0]  cell_exp  [MAX_TERMS];
  logic signed [stat_pkg::COEF_W-1:0] cell_coef [MAX_TERMS];
  logic [MAX_TERMS-1:0]               cell_gt;
  logic [MAX_TERMS-1:0]               cell_match;

  logic in_accept;
  logic out_load;
  logic any_match;
  logic full;
  logic read_last;

  // output register can take a new beat when empty or being drained
  assign out_load  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == S_IDLE) && out_load);
  assign in_accept = in_valid && !in_stall;
  assign any_match = |cell_match;
  assign full      = (count_r == CW'(MAX_TERMS));
  assign read_last = ((idx_r + CW'(1)) == count_r);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // broadcast command to the chain
  always_comb begin
    cmd.mode        = stat_pkg::CELL_HOLD;
    cmd.exponent    = in_data.term_exponent;
    cmd.coefficient = in_data.term_coefficient;
    if (in_accept && in_data.operation == stat_pkg::OP_INSERT) begin
      if (any_match) begin
        cmd.mode = stat_pkg::CELL_MERGE;
      end else if (!full) begin
        cmd.mode = stat_pkg::CELL_INSERT;
      end
    end else if (state_r == S_READ && out_load) begin
      cmd.mode = stat_pkg::CELL_ROTATE;
    end
  end

  // control and output register next values
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_load ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          out_data_nxt = '{status: stat_pkg::ST_PLACED, out_exponent: '0,
                           out_coefficient: '0, last: 1'b1};
          unique case (in_data.operation)
            stat_pkg::OP_INSERT: begin
              out_valid_nxt = 1'b1;
              if (any_match) begin
                out_data_nxt.status = stat_pkg::ST_MERGED;
              end else if (full) begin
                out_data_nxt.status = stat_pkg::ST_DROPPED;
              end else begin
                count_nxt = count_r + CW'(1);
              end
            end
            stat_pkg::OP_READ: begin
              if (count_r == '0) begin
                out_valid_nxt       = 1'b1;
                out_data_nxt.status = stat_pkg::ST_EMPTY;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_READ;
              end
            end
            stat_pkg::OP_CLEAR: begin
              out_valid_nxt       = 1'b1;
              out_data_nxt.status = stat_pkg::ST_CLEARED;
              count_nxt           = '0;
            end
            default: begin
              // unused code: no beat, table untouched
            end
          endcase
        end
      end
      S_READ: begin
        if (out_load) begin
          // head cell goes out while the chain rotates one step
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: stat_pkg::ST_TERM, out_exponent: cell_exp[0],
                            out_coefficient: cell_coef[0], last: read_last};
          idx_nxt       = idx_r + CW'(1);
          if (read_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  // chain of term cells, cell 0 holds the highest exponent
  for (genvar i = 0; i < MAX_TERMS; i++) begin : g_cell
    logic                               valid_c;
    logic                               tail_c;
    logic                               left_gt_c;
    logic signed [stat_pkg::EXP_W-1:0]  left_exp_c;
    logic signed [stat_pkg::COEF_W-1:0] left_coef_c;
    logic signed [stat_pkg::EXP_W-1:0]  right_exp_c;
    logic signed [stat_pkg::COEF_W-1:0] right_coef_c;

    assign valid_c = (count_r > CW'(i));
    assign tail_c  = (count_r == CW'(i + 1));

    if (i == 0) begin : g_head
      assign left_gt_c   = 1'b1;
      assign left_exp_c  = cell_exp[0];
      assign left_coef_c = cell_coef[0];
    end else begin : g_body
      assign left_gt_c   = cell_gt[i-1];
      assign left_exp_c  = cell_exp[i-1];
      assign left_coef_c = cell_coef[i-1];
    end

    if (i == MAX_TERMS - 1) begin : g_end
      assign right_exp_c  = cell_exp[i];
      assign right_coef_c = cell_coef[i];
    end else begin : g_mid
      assign right_exp_c  = cell_exp[i+1];
      assign right_coef_c = cell_coef[i+1];
    end

    stat_cell u_cell (
      .clk          (clk),
      .cmd          (cmd),
      .valid_i      (valid_c),
      .tail_i       (tail_c),
      .left_gt_i    (left_gt_c),
      .left_exp_i   (left_exp_c),
      .left_coef_i  (left_coef_c),
      .right_exp_i  (right_exp_c),
      .right_coef_i (right_coef_c),
      .head_exp_i   (cell_exp[0]),
      .head_coef_i  (cell_coef[0]),
      .exp_o        (cell_exp[i]),
      .coef_o       (cell_coef[i]),
      .gt_o         (cell_gt[i]),
      .match_o      (cell_match[i])
    );
  end

endmodule
